// ===== src/sensor_health_tracker_core_assert.svh =====
// Assertion macros for the sensor health tracker.
// Define ASSERT_OFF to compile the checks out.
`ifndef SENSOR_HEALTH_TRACKER_CORE_ASSERT_SVH
`define SENSOR_HEALTH_TRACKER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define SHT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

`define SHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`else

`define SHT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define SHT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/sht_pkg.sv =====
package sht_pkg;

  // health states, encoding is visible on the result ports
  typedef enum logic [2:0] {
    ST_BOOT  = 3'd0,
    ST_PROBE = 3'd1,
    ST_READY = 3'd2,
    ST_TRANS = 3'd3,
    ST_FAULT = 3'd4
  } health_e;

  // operation codes
  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // config register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_READY_SUCCESS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUNTIME_FAILURES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_FAILURES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RUNTIME_GRACE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSIENT_GRACE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP_GRACE    = 3'd5;

  // field widths
  localparam int unsigned THRESH_W = 8;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned CFG_W    = 32;

endpackage

// ===== src/sensor_health_tracker_core.sv =====
// Sensor health tracker. Each input beat is either a restart or an
// observation of a distance sensor (present, link ok, distance valid) with a
// millisecond time stamp; each beat yields exactly one result beat with the
// health state before and after it (booting, probing, ready, transient,
// fault) and a changed flag. The block takes one beat per clock cycle
// sustained while the output is not stalled: a beat lands in an input
// register, the whole state update is done in one pass of logic from there
// into the result register, which drives the output. An output stall holds
// the result register and backs up into the input register, so at most two
// beats are in flight. Run counters saturate at 2^COUNT_WIDTH-1; time is
// kept at TIME_WIDTH bits and a zero time stamp in the start or last-ready
// time means unset. Config registers are written on the cfg channel (always
// ready); the user must write them only while no beat is in flight, the
// block itself does not enforce this. Indexes past the last register are
// dropped.
`include "sensor_health_tracker_core_assert.svh"

module sensor_health_tracker_core
  import sht_pkg::*;
#(
  parameter int unsigned TIME_WIDTH  = 32,
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 operation_i,
  input  logic [MS_W-1:0]      now_ms_i,
  input  logic                 sensor_present_i,
  input  logic                 link_ok_i,
  input  logic                 distance_valid_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           previous_state_o,
  output logic [2:0]           next_state_o,
  output logic                 state_changed_o
);

  // compare widths wide enough for both sides
  localparam int unsigned TCMP_W = (TIME_WIDTH > MS_W) ? TIME_WIDTH : MS_W;
  localparam int unsigned KCMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [TIME_WIDTH-1:0]  TIME_MAX = {TIME_WIDTH{1'b1}};

  // ---------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------
  logic [THRESH_W-1:0] ready_success_q;
  logic [THRESH_W-1:0] runtime_failures_q;
  logic [THRESH_W-1:0] startup_failures_q;  // stored only
  logic [MS_W-1:0]     runtime_grace_q;
  logic [MS_W-1:0]     transient_grace_q;   // stored only
  logic [MS_W-1:0]     startup_grace_q;

  logic cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_success_q    <= THRESH_W'(3);
      runtime_failures_q <= THRESH_W'(3);
      startup_failures_q <= THRESH_W'(3);
      runtime_grace_q    <= MS_W'(1000);
      transient_grace_q  <= MS_W'(500);
      startup_grace_q    <= MS_W'(3000);
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_READY_SUCCESS:    ready_success_q    <= cfg_data_i[THRESH_W-1:0];
        REG_RUNTIME_FAILURES: runtime_failures_q <= cfg_data_i[THRESH_W-1:0];
        REG_STARTUP_FAILURES: startup_failures_q <= cfg_data_i[THRESH_W-1:0];
        REG_RUNTIME_GRACE:    runtime_grace_q    <= cfg_data_i;
        REG_TRANSIENT_GRACE:  transient_grace_q  <= cfg_data_i;
        REG_STARTUP_GRACE:    startup_grace_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // handshake: input register -> result register
  // ---------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_free;     // result register can take a new beat
  logic in_accept;
  logic s1_fire;      // input register beat is processed this cycle

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // input payload register
  logic            s1_op_q;
  logic [MS_W-1:0] s1_now_q;
  logic            s1_present_q;
  logic            s1_good_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q      <= operation_i;
      s1_now_q     <= now_ms_i;
      s1_present_q <= sensor_present_i;
      s1_good_q    <= link_ok_i && distance_valid_i;
    end
  end

  // ---------------------------------------------------------------------
  // tracker state
  // ---------------------------------------------------------------------
  health_e                state_q, state_d;
  logic [TIME_WIDTH-1:0]  start_q, start_d;
  logic [TIME_WIDTH-1:0]  last_ready_q, last_ready_d;
  logic [COUNT_WIDTH-1:0] succ_q, succ_d;
  logic [COUNT_WIDTH-1:0] fail_q, fail_d;
  logic                   ever_q, ever_d;

  logic [TIME_WIDTH-1:0]  now_t;
  logic [TIME_WIDTH-1:0]  start_eff;   // start time after unset fill
  logic [COUNT_WIDTH-1:0] succ_inc, fail_inc;
  logic [TIME_WIDTH-1:0]  age, since;
  logic                   ready_hit, startup_ok, runtime_fault;

  assign now_t     = TIME_WIDTH'(s1_now_q);
  assign start_eff = (start_q == '0) ? now_t : start_q;
  assign succ_inc  = (succ_q == CNT_MAX) ? CNT_MAX : succ_q + 1'b1;
  assign fail_inc  = (fail_q == CNT_MAX) ? CNT_MAX : fail_q + 1'b1;

  // time going backwards counts as zero age
  assign age   = (now_t >= start_eff) ? now_t - start_eff : '0;
  // unset or backwards last-ready time reads as "long ago"
  assign since = (last_ready_q != '0 && now_t >= last_ready_q) ?
                 now_t - last_ready_q : TIME_MAX;

  assign ready_hit     = KCMP_W'(succ_inc) >= KCMP_W'(ready_success_q);
  assign startup_ok    = TCMP_W'(age) < TCMP_W'(startup_grace_q);
  assign runtime_fault = (KCMP_W'(fail_inc) >= KCMP_W'(runtime_failures_q)) &&
                         (TCMP_W'(since) >= TCMP_W'(runtime_grace_q));

  always_comb begin
    state_d      = state_q;
    start_d      = start_q;
    last_ready_d = last_ready_q;
    succ_d       = succ_q;
    fail_d       = fail_q;
    ever_d       = ever_q;
    if (s1_op_q == OP_RESTART) begin
      state_d      = s1_present_q ? ST_BOOT : ST_FAULT;
      start_d      = now_t;
      last_ready_d = '0;
      succ_d       = '0;
      fail_d       = '0;
      ever_d       = 1'b0;
    end else if (!s1_present_q) begin
      // sensor gone: last-ready time survives
      state_d = ST_FAULT;
      start_d = now_t;
      succ_d  = '0;
      fail_d  = '0;
      ever_d  = 1'b0;
    end else begin
      start_d = start_eff;
      if (s1_good_q) begin
        succ_d = succ_inc;
        fail_d = '0;
        if (ready_hit) begin
          state_d      = ST_READY;
          ever_d       = 1'b1;
          last_ready_d = now_t;
        end else if (!ever_q) begin
          state_d = ST_PROBE;
        end
      end else begin
        succ_d = '0;
        fail_d = fail_inc;
        if (!ever_q) begin
          state_d = startup_ok ? ST_PROBE : ST_FAULT;
        end else if (runtime_fault) begin
          state_d = ST_FAULT;
        end else begin
          state_d = ST_TRANS;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_BOOT;
      start_q      <= '0;
      last_ready_q <= '0;
      succ_q       <= '0;
      fail_q       <= '0;
      ever_q       <= 1'b0;
    end else if (s1_fire) begin
      state_q      <= state_d;
      start_q      <= start_d;
      last_ready_q <= last_ready_d;
      succ_q       <= succ_d;
      fail_q       <= fail_d;
      ever_q       <= ever_d;
    end
  end

  // result register
  logic [2:0] prev_q, next_q;
  logic       changed_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      prev_q    <= state_q;
      next_q    <= state_d;
      changed_q <= (state_d != state_q);
    end
  end

  assign previous_state_o = prev_q;
  assign next_state_o     = next_q;
  assign state_changed_o  = changed_q;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  // stall is only raised while the input register holds a beat
  `SHT_ASSERT_IMPLY(a_stall_has_beat, clk_i, rst_ni, in_stall_o, s1_valid_q)
  // a processed beat shows up next cycle carrying the state it started from
  `SHT_ASSERT_NEXT(a_result_prev, clk_i, rst_ni, s1_fire,
                   out_valid_o && (previous_state_o == 3'($past(state_q))))
  // while the ever-ready flag is set (cleared by restart or sensor loss), the state is neither boot nor probe
  `SHT_ASSERT_IMPLY(a_ever_ready_state, clk_i, rst_ni, ever_q,
                    (state_q != ST_BOOT) && (state_q != ST_PROBE))

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import sht_pkg::*;

  // Watchdog: cycles in a row with no beat on any channel.
  // The longest legal quiet stretch is the long output hold (LONG_HOLD).
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 200;
  localparam int unsigned N_DIR          = 24;

  typedef struct packed {
    logic            op;
    logic [MS_W-1:0] now_ms;
    logic            present;
    logic            link_ok;
    logic            dist_ok;
  } reading_t;

  typedef struct packed {
    health_e prev_st;
    health_e next_st;
    logic    changed;
  } health_result_t;

  typedef struct packed {
    logic [THRESH_W-1:0] ready_samples;
    logic [THRESH_W-1:0] runtime_failures;
    logic [THRESH_W-1:0] startup_failures;
    logic [CFG_W-1:0]    runtime_grace;
    logic [CFG_W-1:0]    transient_grace;
    logic [CFG_W-1:0]    startup_grace;
  } cfg_set_t;

  // One directed beat. When 'typed' is set the result is the one written in
  // the row; otherwise it comes from the tracker model below.
  typedef struct packed {
    reading_t       rd;
    logic           typed;
    health_result_t want;
  } dir_row_t;

  // Directed sequence under reset settings: ready 3, runtime failures 3,
  // runtime grace 1000, startup grace 3000.
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // first good sample after reset: start time stays unset at zero
    '{'{OP_OBSERVE, 32'd0,    1'b1, 1'b1, 1'b1}, 1'b1, '{ST_BOOT,  ST_PROBE, 1'b1}},
    '{'{OP_OBSERVE, 32'd100,  1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{OP_OBSERVE, 32'd200,  1'b1, 1'b1, 1'b1}, 1'b0, '0},  // reaches ready
    '{'{OP_OBSERVE, 32'd300,  1'b1, 1'b0, 1'b1}, 1'b0, '0},  // link lost
    '{'{OP_OBSERVE, 32'd400,  1'b1, 1'b1, 1'b0}, 1'b0, '0},  // bad distance
    '{'{OP_OBSERVE, 32'd1300, 1'b1, 1'b0, 1'b0}, 1'b0, '0},  // runtime fault
    '{'{OP_OBSERVE, 32'd1400, 1'b1, 1'b1, 1'b1}, 1'b0, '0},  // good, below threshold
    '{'{OP_OBSERVE, 32'd1500, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{OP_OBSERVE, 32'd1600, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{OP_OBSERVE, 32'd1700, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_OBSERVE, 32'd1800, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
    '{'{OP_OBSERVE, 32'd1900, 1'b1, 1'b1, 1'b0}, 1'b0, '0},  // inside runtime grace
    '{'{OP_OBSERVE, 32'd5,    1'b1, 1'b0, 1'b0}, 1'b0, '0},  // time goes backwards
    // sensor missing while observing
    '{'{OP_OBSERVE, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1}, 1'b1, '{ST_FAULT, ST_FAULT, 1'b0}},
    '{'{OP_OBSERVE, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_OBSERVE, 32'd10,   1'b1, 1'b0, 1'b0}, 1'b0, '0},  // startup age clamps to 0
    '{'{OP_RESTART, 32'd0,    1'b1, 1'b0, 1'b0}, 1'b1, '{ST_PROBE, ST_BOOT,  1'b1}},
    '{'{OP_OBSERVE, 32'd0,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_OBSERVE, 32'd3000, 1'b1, 1'b0, 1'b0}, 1'b0, '0},  // unset start picks 3000
    '{'{OP_OBSERVE, 32'd6000, 1'b1, 1'b1, 1'b0}, 1'b0, '0},  // startup grace ran out
    // restart without sensor, link and distance flags are don't-care
    '{'{OP_RESTART, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1}, 1'b1, '{ST_FAULT, ST_FAULT, 1'b0}},
    '{'{OP_RESTART, 32'd7,    1'b1, 1'b0, 1'b0}, 1'b1, '{ST_FAULT, ST_BOOT,  1'b1}},
    '{'{OP_OBSERVE, 32'd8,    1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{OP_RESTART, 32'd12345, 1'b1, 1'b1, 1'b1}, 1'b1, '{ST_PROBE, ST_BOOT, 1'b1}}
  };

  // DUT ports
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 operation_i;
  logic [MS_W-1:0]      now_ms_i;
  logic                 sensor_present_i;
  logic                 link_ok_i;
  logic                 distance_valid_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [2:0]           previous_state_o;
  logic [2:0]           next_state_o;
  logic                 state_changed_o;

  // Tracker model: configuration (reset values) and state.
  logic [THRESH_W-1:0] thr_ready    = 8'd3;
  logic [THRESH_W-1:0] thr_fail     = 8'd3;
  logic [THRESH_W-1:0] thr_startup  = 8'd3;    // stored only, no effect
  logic [MS_W-1:0]     grace_run    = 32'd1000;
  logic [MS_W-1:0]     grace_trans  = 32'd500; // stored only, no effect
  logic [MS_W-1:0]     grace_start  = 32'd3000;

  health_e             track_st   = ST_BOOT;
  logic [MS_W-1:0]     t_start    = '0;        // zero means unset
  logic [MS_W-1:0]     t_ready    = '0;        // zero means unset
  logic [THRESH_W-1:0] ok_run     = '0;
  logic [THRESH_W-1:0] bad_run    = '0;
  logic                was_ready  = 1'b0;

  health_result_t state_reports_q [$];
  health_result_t want_r;
  int unsigned    bad_reports = 0;
  int unsigned    burst_left  = 0;
  int unsigned    long_holds_req = 0;  // bumped by the sender, one hold each

  sensor_health_tracker_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .now_ms_i         (now_ms_i),
    .sensor_present_i (sensor_present_i),
    .link_ok_i        (link_ok_i),
    .distance_valid_i (distance_valid_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .previous_state_o (previous_state_o),
    .next_state_o     (next_state_o),
    .state_changed_o  (state_changed_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run counters stick at all-ones.
  function automatic logic [THRESH_W-1:0] sat_inc(input logic [THRESH_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Advance the tracker by one reading, return the state report it yields.
  function automatic health_result_t advance_health(input reading_t r);
    health_result_t  res;
    logic [MS_W-1:0] age;
    logic [MS_W-1:0] since;
    res.prev_st = track_st;
    if (r.op == OP_RESTART) begin
      track_st  = r.present ? ST_BOOT : ST_FAULT;
      t_start   = r.now_ms;
      t_ready   = '0;
      ok_run    = '0;
      bad_run   = '0;
      was_ready = 1'b0;
    end else if (!r.present) begin
      // sensor gone: fault, but the last ready time survives
      track_st  = ST_FAULT;
      t_start   = r.now_ms;
      ok_run    = '0;
      bad_run   = '0;
      was_ready = 1'b0;
    end else begin
      if (t_start == '0) t_start = r.now_ms;
      if (r.link_ok && r.dist_ok) begin
        ok_run  = sat_inc(ok_run);
        bad_run = '0;
        if (ok_run >= thr_ready) begin
          track_st  = ST_READY;
          was_ready = 1'b1;
          t_ready   = r.now_ms;
        end else if (!was_ready) begin
          track_st = ST_PROBE;
        end
      end else begin
        ok_run  = '0;
        bad_run = sat_inc(bad_run);
        // backwards time: age clamps to 0, time since ready to the maximum
        age   = (r.now_ms >= t_start) ? r.now_ms - t_start : '0;
        since = (t_ready != '0 && r.now_ms >= t_ready) ? r.now_ms - t_ready : '1;
        if (!was_ready) begin
          track_st = (age < grace_start) ? ST_PROBE : ST_FAULT;
        end else if (bad_run >= thr_fail && since >= grace_run) begin
          track_st = ST_FAULT;
        end else begin
          track_st = ST_TRANS;
        end
      end
    end
    res.next_st = track_st;
    res.changed = (res.prev_st != res.next_st);
    return res;
  endfunction

  // Offer one reading and hold it until the beat is taken. Returns at the
  // accepting edge; valid stays high so a following beat can go back to back.
  task automatic push_item(input reading_t r, input bit has_typed,
                           input health_result_t typed);
    health_result_t res;
    in_valid_i       <= 1'b1;
    operation_i      <= r.op;
    now_ms_i         <= r.now_ms;
    sensor_present_i <= r.present;
    link_ok_i        <= r.link_ok;
    distance_valid_i <= r.dist_ok;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    res = advance_health(r);
    state_reports_q.push_back(has_typed ? typed : res);
  endtask

  // Sender pacing: bursts of random length, some followed by a gap.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stop offering and wait until every report is back. Each beat yields
  // exactly one report, so an empty queue means nothing is in flight.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (state_reports_q.size() != 0) @(posedge clk_i);
  endtask

  // Write all registers back to back, plus the two unused indexes.
  task automatic apply_settings(input cfg_set_t s);
    logic [CFG_W-1:0]     data;
    logic [CFG_IDX_W-1:0] idx;
    for (int i = 0; i < 2**CFG_IDX_W; i++) begin
      idx  = CFG_IDX_W'(i);
      data = $urandom;
      // narrow registers get junk in the upper bits, it must be dropped
      case (idx)
        REG_READY_SUCCESS: begin
          data[THRESH_W-1:0] = s.ready_samples;
          thr_ready = s.ready_samples;
        end
        REG_RUNTIME_FAILURES: begin
          data[THRESH_W-1:0] = s.runtime_failures;
          thr_fail = s.runtime_failures;
        end
        REG_STARTUP_FAILURES: begin
          data[THRESH_W-1:0] = s.startup_failures;
          thr_startup = s.startup_failures;
        end
        REG_RUNTIME_GRACE: begin
          data = s.runtime_grace;
          grace_run = data;
        end
        REG_TRANSIENT_GRACE: begin
          data = s.transient_grace;
          grace_trans = data;
        end
        REG_STARTUP_GRACE: begin
          data = s.startup_grace;
          grace_start = data;
        end
        default: ;  // unknown index, dropped by the block
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // One episode: mostly a restart followed by observations with time moving
  // forward in small steps, good and bad samples in runs. A little noise
  // (sensor loss, mid-run restart, time jumps) is mixed in. With fixed_run
  // set, one clean good run then one clean bad run of that length.
  task automatic random_episode(input int unsigned len, input int unsigned fixed_run);
    reading_t        r;
    logic [MS_W-1:0] t;
    int unsigned     left;
    bit              good;
    case ($urandom_range(0, 3))
      0:       t = '0;
      1:       t = $urandom;
      2:       t = 32'hFFFF_F800 + $urandom_range(0, 2047);  // wraps soon
      default: t = $urandom_range(1, 5000);
    endcase
    left = 0;
    good = 1'b1;
    for (int unsigned n = 0; n < len; n++) begin
      r.op      = OP_OBSERVE;
      r.present = 1'b1;
      if (n == 0) begin
        r.op      = (fixed_run != 0 || $urandom_range(0, 7) != 0) ? OP_RESTART : OP_OBSERVE;
        r.present = (fixed_run != 0 || $urandom_range(0, 7) != 0);
        r.link_ok = 1'($urandom);
        r.dist_ok = 1'($urandom);
      end else begin
        if (fixed_run != 0) begin
          t = t + $urandom_range(1, 20);
        end else begin
          case ($urandom_range(0, 29))
            0:       t = t - $urandom_range(1, 3000);
            1:       t = '0;
            2:       t = $urandom;
            default: t = t + $urandom_range(0, 900);
          endcase
        end
        if (left == 0) begin
          if (fixed_run != 0) begin
            good = (n == 1);
            left = fixed_run;
          end else begin
            good = 1'($urandom_range(0, 1));
            left = $urandom_range(1, 8);
          end
        end
        left--;
        {r.link_ok, r.dist_ok} = good ? 2'b11 : 2'($urandom_range(0, 2));
        if (fixed_run == 0) begin
          case ($urandom_range(0, 39))
            0: begin
              r.op      = OP_RESTART;
              r.present = 1'($urandom);
            end
            1, 2:    r.present = 1'b0;
            default: ;
          endcase
        end
      end
      r.now_ms = t;
      push_item(r, 1'b0, '0);
      pace_sender();
    end
  endtask

  // Result checker: every accepted report against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (state_reports_q.size() == 0) begin
        if (bad_reports < 10)
          $display("%0t: report with none expected: prev %0d next %0d chg %0b",
                   $realtime, previous_state_o, next_state_o, state_changed_o);
        bad_reports++;
      end else begin
        want_r = state_reports_q.pop_front();
        if (previous_state_o !== want_r.prev_st || next_state_o !== want_r.next_st ||
            state_changed_o !== want_r.changed) begin
          if (bad_reports < 10)
            $display("%0t: report mismatch: exp prev %0d next %0d chg %0b, got %0d %0d %0b",
                     $realtime, want_r.prev_st, want_r.next_st, want_r.changed,
                     previous_state_o, next_state_o, state_changed_o);
          bad_reports++;
        end
      end
    end
  end

  // Receiver: stall modes that change after spans of random length, plus a long
  // hold-off on request so the block fills and stalls its input.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned hold_left;
    int unsigned tick;
    int unsigned holds_done;
    out_stall_i = 1'b0;
    mode       = 0;
    span       = 0;
    hold_left  = 0;
    tick       = 0;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_left == 0 && holds_done != long_holds_req) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(5, 60);
        end
        span--;
        case (mode)
          0:       out_stall_i <= 1'b0;                          // free flowing
          1:       out_stall_i <= ($urandom_range(0, 99) < 35);
          2:       out_stall_i <= ((tick % 5) < 2);              // periodic
          default: out_stall_i <= ($urandom_range(0, 99) < 75);  // heavy
        endcase
      end
    end
  end

  // Watchdog: quiet cycles on all three channels.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && out_stall_i === 1'b0) ||
          (cfg_valid_i === 1'b1 && cfg_ready_o === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("[sensor_health_tracker_core] ERROR");
    $finish;
  end

  initial begin : stimulus
    cfg_set_t plan;
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    operation_i      = OP_OBSERVE;
    now_ms_i         = '0;
    sensor_present_i = 1'b0;
    link_ok_i        = 1'b0;
    distance_valid_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed beats under reset settings
    for (int i = 0; i < N_DIR; i++) begin
      push_item(DIR_ROWS[i].rd, DIR_ROWS[i].typed, DIR_ROWS[i].want);
      pace_sender();
    end

    // random phases, each with its own register settings
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      plan = $bits(cfg_set_t)'({$urandom, $urandom, $urandom, $urandom});
      case (phase)
        // ready and runtime-failure thresholds of one, zero grace times
        0: plan = '{8'd1, 8'd1, 8'd0, 32'd0, 32'd0, 32'd0};
        // zero ready and runtime-failure thresholds (every good sample is ready), maximum grace times
        1: plan = '{8'd0, 8'd0, 8'hFF, '1, '1, '1};
        // maximum thresholds, long runs also hit counter saturation
        2: begin
          plan.ready_samples    = 8'hFF;
          plan.runtime_failures = 8'hFF;
          plan.runtime_grace    = $urandom_range(0, 200);
        end
        3, 4: begin
          plan.ready_samples    = THRESH_W'($urandom_range(1, 6));
          plan.runtime_failures = THRESH_W'($urandom_range(1, 6));
          plan.runtime_grace    = $urandom_range(0, 3000);
          plan.startup_grace    = $urandom_range(0, 5000);
        end
        default: plan = '{8'd3, 8'd3, 8'd3, 32'd1000, 32'd500, 32'd3000};
      endcase
      apply_settings(plan);
      if (phase == 0 || phase == 3) long_holds_req++;
      if (phase == 2) begin
        random_episode(513, 256);
      end else begin
        repeat (3) random_episode($urandom_range(10, 20), 0);
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (bad_reports == 0 && state_reports_q.size() == 0) begin
      $display("[sensor_health_tracker_core] OK");
    end else begin
      $display("[sensor_health_tracker_core] ERROR");
    end
    $finish;
  end

endmodule
